// ===== rtl/dsvm_pkg.sv =====
package dsvm_pkg;

  localparam int VoicesDef      = 16;
  localparam int SlotsDef       = 16;
  localparam int SampleDepthDef = 65536;

  localparam logic [15:0] MasterGainReset = 16'd16384;
  localparam logic [23:0] EnvFull         = 24'h800000;
  // ceil(2^30 / 127): exact quotient by 127 for any 23-bit dividend.
  localparam logic [23:0] Recip127        = 24'd8454661;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_NOTE = 2'd1,
    FN_LOAD = 2'd2,
    FN_SET  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    SET_NOTE   = 4'd0,
    SET_CHOKE  = 4'd1,
    SET_START  = 4'd2,
    SET_BASE   = 4'd3,
    SET_LENGTH = 4'd4,
    SET_INCR   = 4'd5,
    SET_LEVEL  = 4'd6,
    SET_PANL   = 4'd7,
    SET_PANR   = 4'd8,
    SET_DECAY  = 4'd9
  } set_e;

  typedef struct packed {
    logic latch;
    logic load_wr;
    logic set_wr;
    logic trg_chk;
    logic trg_fire;
    logic vchk;
    logic rd;
    logic c1;
    logic c2;
    logic c3;
    logic m1;
    logic m2;
    logic fin1;
    logic fin2;
  } cmd_t;

  typedef struct packed {
    logic vel_nz;
    logic slot_hit;
    logic voice_live;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/dsvm_ram.sv =====
module dsvm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dsvm_ctrl.sv =====
module dsvm_ctrl #(
  parameter int VOICES = dsvm_pkg::VoicesDef,
  parameter int SLOTS  = dsvm_pkg::SlotsDef,
  localparam int VoiceW = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int SlotW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  dsvm_pkg::sts_t    sts_i,
  output dsvm_pkg::cmd_t    cmd_o,
  output logic [VoiceW-1:0] vidx_o,
  output logic [SlotW-1:0]  sidx_o,
  output logic [1:0]        phase_o
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_TRG0 = 13'b0000000000010,
    S_TRG1 = 13'b0000000000100,
    S_VCHK = 13'b0000000001000,
    S_RD   = 13'b0000000010000,
    S_RDW  = 13'b0000000100000,
    S_C1   = 13'b0000001000000,
    S_C2   = 13'b0000010000000,
    S_C3   = 13'b0000100000000,
    S_M1   = 13'b0001000000000,
    S_M2   = 13'b0010000000000,
    S_FIN1 = 13'b0100000000000,
    S_FIN2 = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [VoiceW-1:0] vidx_q, vidx_d;
  logic [SlotW-1:0]  sidx_q, sidx_d;
  logic [1:0]        phase_q, phase_d;
  logic              last_voice, last_slot;

  assign last_voice = (vidx_q == VoiceW'(VOICES - 1));
  assign last_slot  = (sidx_q == SlotW'(SLOTS - 1));

  always_comb begin
    state_d = state_q;
    vidx_d  = vidx_q;
    sidx_d  = sidx_q;
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (dsvm_pkg::func_e'(func_i))
            dsvm_pkg::FN_TICK: begin
              state_d = S_VCHK;
              vidx_d  = '0;
            end
            dsvm_pkg::FN_NOTE: begin
              if (sts_i.vel_nz) begin
                state_d = S_TRG0;
                sidx_d  = '0;
              end
            end
            dsvm_pkg::FN_LOAD: cmd_o.load_wr = 1'b1;
            dsvm_pkg::FN_SET:  cmd_o.set_wr = 1'b1;
          endcase
        end
      end
      S_TRG0: begin
        cmd_o.trg_chk = 1'b1;
        if (sts_i.slot_hit) begin
          state_d = S_TRG1;
        end else if (last_slot) begin
          state_d = S_IDLE;
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
      S_TRG1: begin
        cmd_o.trg_fire = 1'b1;
        if (last_slot) begin
          state_d = S_IDLE;
        end else begin
          sidx_d  = sidx_q + 1'b1;
          state_d = S_TRG0;
        end
      end
      S_VCHK: begin
        cmd_o.vchk = 1'b1;
        if (sts_i.voice_live) begin
          state_d = S_RD;
          phase_d = '0;
        end else if (last_voice) begin
          state_d = S_FIN1;
        end else begin
          vidx_d = vidx_q + 1'b1;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        phase_d  = phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          state_d = S_RDW;
        end
      end
      S_RDW: state_d = S_C1;
      S_C1: begin
        cmd_o.c1 = 1'b1;
        state_d  = S_C2;
      end
      S_C2: begin
        cmd_o.c2 = 1'b1;
        state_d  = S_C3;
      end
      S_C3: begin
        cmd_o.c3 = 1'b1;
        state_d  = S_M1;
      end
      S_M1: begin
        cmd_o.m1 = 1'b1;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.m2 = 1'b1;
        if (last_voice) begin
          state_d = S_FIN1;
        end else begin
          vidx_d  = vidx_q + 1'b1;
          state_d = S_VCHK;
        end
      end
      S_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = S_FIN2;
      end
      S_FIN2: begin
        // Hold the finished mix until the output register is free.
        if (!sts_i.out_busy) begin
          cmd_o.fin2 = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vidx_q  <= '0;
      sidx_q  <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      vidx_q  <= vidx_d;
      sidx_q  <= sidx_d;
      phase_q <= phase_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign vidx_o     = vidx_q;
  assign sidx_o     = sidx_q;
  assign phase_o    = phase_q;

  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin2 |-> !sts_i.out_busy)
    else $error("result loaded while output register is held");

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && func_i == dsvm_pkg::FN_TICK)
      |=> (state_q == S_VCHK && vidx_q == '0))
    else $error("tick did not start at the first voice");

  a_rd_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD && phase_q != 2'd3)
      |=> (state_q == S_RD && phase_q == $past(phase_q) + 2'd1))
    else $error("sample read phases out of order");

  a_last_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M2 && last_voice) |=> (state_q == S_FIN1))
    else $error("tick did not close after the last voice");

endmodule

// ===== rtl/dsvm_dp.sv =====
module dsvm_dp #(
  parameter int VOICES       = dsvm_pkg::VoicesDef,
  parameter int SLOTS        = dsvm_pkg::SlotsDef,
  parameter int SAMPLE_DEPTH = dsvm_pkg::SampleDepthDef,
  localparam int VoiceW = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int SlotW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsvm_pkg::cmd_t      cmd_i,
  output dsvm_pkg::sts_t      sts_o,
  input  logic [VoiceW-1:0]   vidx_i,
  input  logic [SlotW-1:0]    sidx_i,
  input  logic [1:0]          phase_i,
  input  logic [6:0]          note_i,
  input  logic [6:0]          velocity_i,
  input  logic [3:0]          slot_index_i,
  input  logic [3:0]          setting_code_i,
  input  logic [23:0]         setting_value_i,
  input  logic [15:0]         sample_address_i,
  input  logic signed [15:0]  sample_left_i,
  input  logic signed [15:0]  sample_right_i,
  input  logic [15:0]         master_gain_i,
  output logic signed [23:0]  out_left_o,
  output logic signed [23:0]  out_right_o,
  output logic [4:0]          voices_busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);

  localparam int AW = $clog2(SAMPLE_DEPTH);

  // Slot table.
  logic [7:0]  sl_note_q  [SLOTS];
  logic [2:0]  sl_choke_q [SLOTS];
  logic [23:0] sl_start_q [SLOTS];
  logic [23:0] sl_base_q  [SLOTS];
  logic [23:0] sl_len_q   [SLOTS];
  logic [23:0] sl_incr_q  [SLOTS];
  logic [15:0] sl_level_q [SLOTS];
  logic [15:0] sl_panl_q  [SLOTS];
  logic [15:0] sl_panr_q  [SLOTS];
  logic [23:0] sl_decay_q [SLOTS];

  // Voice state.
  logic              v_act_q   [VOICES];
  logic [SlotW-1:0]  v_slot_q  [VOICES];
  logic [2:0]        v_choke_q [VOICES];
  logic [39:0]       v_pos_q   [VOICES];
  logic [15:0]       v_gain_q  [VOICES];
  logic [23:0]       v_env_q   [VOICES];
  logic [VoiceW-1:0] next_q;

  // Working registers of the voice in progress.
  logic [6:0]  note_q, vel_q;
  logic [22:0] prod_q;
  logic [23:0] w_base_q, w_len_q, w_incr_q, w_decay_q, w_env_q;
  logic [15:0] w_panl_q, w_panr_q, w_gain_q, g_q;
  logic [39:0] w_pos_q;
  logic        rd_pend_q;
  logic [1:0]  rd_sel_q;
  logic signed [15:0] pw_q   [2][4];
  logic signed [26:0] y_q    [2];
  logic signed [43:0] sg_q   [2];
  logic signed [39:0] acc_q  [2];
  logic signed [42:0] fo_q   [2];
  logic [4:0]         busy_q;
  logic signed [23:0] out_q  [2];
  logic [4:0]         out_busy_q;
  logic               out_valid_q;

  // Slot write decode.
  logic             set_ok;
  logic [SlotW-1:0] set_idx;
  logic [15:0]      val_sat;

  assign set_ok  = int'(slot_index_i) < SLOTS;
  assign set_idx = SlotW'(slot_index_i);
  assign val_sat = (|setting_value_i[23:16]) ? 16'hFFFF : setting_value_i[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        sl_note_q[k]  <= '0;
        sl_choke_q[k] <= '0;
        sl_start_q[k] <= '0;
        sl_base_q[k]  <= '0;
        sl_len_q[k]   <= '0;
        sl_incr_q[k]  <= '0;
        sl_level_q[k] <= '0;
        sl_panl_q[k]  <= '0;
        sl_panr_q[k]  <= '0;
        sl_decay_q[k] <= '0;
      end
    end else if (cmd_i.set_wr && set_ok) begin
      case (dsvm_pkg::set_e'(setting_code_i))
        dsvm_pkg::SET_NOTE:   sl_note_q[set_idx]  <= setting_value_i[7:0];
        dsvm_pkg::SET_CHOKE:  sl_choke_q[set_idx] <= setting_value_i[2:0];
        dsvm_pkg::SET_START:  sl_start_q[set_idx] <= setting_value_i;
        dsvm_pkg::SET_BASE:   sl_base_q[set_idx]  <= setting_value_i;
        dsvm_pkg::SET_LENGTH: sl_len_q[set_idx]   <= setting_value_i;
        dsvm_pkg::SET_INCR:   sl_incr_q[set_idx]  <= setting_value_i;
        dsvm_pkg::SET_LEVEL:  sl_level_q[set_idx] <= val_sat;
        dsvm_pkg::SET_PANL:   sl_panl_q[set_idx]  <= val_sat;
        dsvm_pkg::SET_PANR:   sl_panr_q[set_idx]  <= val_sat;
        dsvm_pkg::SET_DECAY:  sl_decay_q[set_idx] <= setting_value_i;
        default: ;
      endcase
    end
  end

  // Trigger and voice check.
  logic             slot_hit, voice_live;
  logic [SlotW-1:0] vs;
  logic [39:0]      vend;
  logic [46:0]      gmul;
  logic [2:0]       tchoke;

  assign slot_hit   = (sl_note_q[sidx_i] == {1'b0, note_q}) && (sl_len_q[sidx_i] != '0);
  assign vs         = v_slot_q[vidx_i];
  assign vend       = {sl_len_q[vs], 16'h0000};
  assign voice_live = v_act_q[vidx_i] && (v_pos_q[vidx_i] < vend);
  assign gmul       = {24'd0, prod_q} * {23'd0, dsvm_pkg::Recip127};
  assign tchoke     = sl_choke_q[sidx_i];

  // Position and envelope after this tick.
  logic [40:0] pos_sum, pos_end;
  logic [39:0] pos_nx;

  assign pos_sum = {1'b0, w_pos_q} + {17'd0, w_incr_q};
  assign pos_end = {1'b0, w_len_q, 16'h0000};
  assign pos_nx  = (pos_sum > pos_end) ? pos_end[39:0] : pos_sum[39:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VOICES; k++) begin
        v_act_q[k]   <= 1'b0;
        v_slot_q[k]  <= '0;
        v_choke_q[k] <= '0;
        v_pos_q[k]   <= '0;
        v_gain_q[k]  <= '0;
        v_env_q[k]   <= '0;
      end
      next_q <= '0;
    end else begin
      if (cmd_i.trg_fire) begin
        // Choke first; the voice taken below is then set active again.
        for (int k = 0; k < VOICES; k++) begin
          if (tchoke != 3'd0 && v_act_q[k] && v_choke_q[k] == tchoke) begin
            v_act_q[k] <= 1'b0;
          end
        end
        v_act_q[next_q]   <= 1'b1;
        v_slot_q[next_q]  <= sidx_i;
        v_choke_q[next_q] <= tchoke;
        v_pos_q[next_q]   <= {sl_start_q[sidx_i], 16'h0000};
        v_gain_q[next_q]  <= gmul[45:30];
        v_env_q[next_q]   <= dsvm_pkg::EnvFull;
        next_q <= (next_q == VoiceW'(VOICES - 1)) ? '0 : next_q + 1'b1;
      end
      if (cmd_i.vchk && !voice_live) begin
        v_act_q[vidx_i] <= 1'b0;
      end
      if (cmd_i.m2) begin
        v_pos_q[vidx_i] <= pos_nx;
        if (w_decay_q != '0) begin
          if (w_decay_q >= w_env_q) begin
            v_env_q[vidx_i] <= '0;
            v_act_q[vidx_i] <= 1'b0;
          end else begin
            v_env_q[vidx_i] <= w_env_q - w_decay_q;
          end
        end
      end
    end
  end

  // Sample memory: left word in the upper half, right in the lower.
  logic [23:0]        load_addr;
  logic signed [25:0] frame;
  logic [23:0]        frame_c;
  logic [24:0]        rd_sum;
  logic [31:0]        rdata;

  assign load_addr = {8'd0, sample_address_i};

  always_comb begin
    frame = $signed({2'b00, w_pos_q[39:16]}) + $signed({24'd0, phase_i}) - 26'sd1;
    if (frame < 26'sd0) begin
      frame_c = '0;
    end else if (frame >= $signed({2'b00, w_len_q})) begin
      frame_c = w_len_q - 24'd1;
    end else begin
      frame_c = frame[23:0];
    end
    rd_sum = {1'b0, w_base_q} + {1'b0, frame_c};
  end

  dsvm_ram #(
    .Width(32),
    .Depth(SAMPLE_DEPTH)
  ) u_wave (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_wr),
    .waddr_i(load_addr[AW-1:0]),
    .wdata_i({sample_left_i, sample_right_i}),
    .raddr_i(rd_sum[AW-1:0]),
    .rdata_o(rdata)
  );

  // Cubic evaluation, one multiply per channel and step; then gain, pan and master gain products.
  logic signed [26:0] y_nx [2];
  logic signed [43:0] sg_nx [2];
  logic signed [60:0] t_nx [2];
  logic signed [56:0] f_nx [2];
  logic signed [16:0] fs, gs, mgs;
  logic [39:0]        gm;

  assign fs  = $signed({1'b0, w_pos_q[15:0]});
  assign gs  = $signed({1'b0, g_q});
  assign mgs = $signed({1'b0, master_gain_i});
  assign gm  = {24'd0, w_gain_q} * {16'd0, w_env_q};

  always_comb begin
    logic signed [19:0] q0, q1, q2, q3, a2, b2, c2;
    logic signed [26:0] op, addend;
    logic signed [43:0] cm;
    logic signed [16:0] pan;
    for (int ch = 0; ch < 2; ch++) begin
      q0 = {{4{pw_q[ch][0][15]}}, pw_q[ch][0]};
      q1 = {{4{pw_q[ch][1][15]}}, pw_q[ch][1]};
      q2 = {{4{pw_q[ch][2][15]}}, pw_q[ch][2]};
      q3 = {{4{pw_q[ch][3][15]}}, pw_q[ch][3]};
      a2 = q3 - q0 + (q1 <<< 1) + q1 - (q2 <<< 1) - q2;
      b2 = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
      c2 = q2 - q0;
      if (cmd_i.c1) begin
        op     = {{7{a2[19]}}, a2};
        addend = {{7{b2[19]}}, b2};
      end else if (cmd_i.c2) begin
        op     = y_q[ch];
        addend = {{7{c2[19]}}, c2};
      end else begin
        op     = y_q[ch];
        addend = {{11{q1[15]}}, q1[15:0]};
      end
      cm = op * fs;
      // The last step also folds in the halving of the polynomial.
      y_nx[ch]  = (cmd_i.c3 ? $signed(cm[43:17]) : $signed(cm[42:16])) + addend;
      sg_nx[ch] = y_q[ch] * gs;
      pan       = $signed({1'b0, (ch == 0) ? w_panl_q : w_panr_q});
      t_nx[ch]  = sg_q[ch] * pan;
      f_nx[ch]  = acc_q[ch] * mgs;
    end
  end

  logic [6:0] act_cnt;

  always_comb begin
    act_cnt = '0;
    for (int k = 0; k < VOICES; k++) begin
      act_cnt = act_cnt + {6'd0, v_act_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      note_q   <= note_i;
      vel_q    <= velocity_i;
      acc_q[0] <= '0;
      acc_q[1] <= '0;
    end
    if (cmd_i.trg_chk) begin
      prod_q <= ({7'd0, sl_level_q[sidx_i]} * {16'd0, vel_q}) + 23'd63;
    end
    if (cmd_i.vchk) begin
      w_base_q  <= sl_base_q[vs];
      w_len_q   <= sl_len_q[vs];
      w_incr_q  <= sl_incr_q[vs];
      w_panl_q  <= sl_panl_q[vs];
      w_panr_q  <= sl_panr_q[vs];
      w_decay_q <= sl_decay_q[vs];
      w_pos_q   <= v_pos_q[vidx_i];
      w_gain_q  <= v_gain_q[vidx_i];
      w_env_q   <= v_env_q[vidx_i];
    end
    rd_sel_q <= phase_i;
    if (rd_pend_q) begin
      pw_q[0][rd_sel_q] <= rdata[31:16];
      pw_q[1][rd_sel_q] <= rdata[15:0];
    end
    if (cmd_i.c1) begin
      g_q <= gm[38:23];
    end
    for (int ch = 0; ch < 2; ch++) begin
      if (cmd_i.c1 || cmd_i.c2 || cmd_i.c3) begin
        y_q[ch] <= y_nx[ch];
      end
      if (cmd_i.m1) begin
        sg_q[ch] <= sg_nx[ch];
      end
      if (cmd_i.m2) begin
        acc_q[ch] <= acc_q[ch] + $signed(t_nx[ch][60:21]);
      end
      if (cmd_i.fin1) begin
        fo_q[ch] <= f_nx[ch][56:14];
      end
      if (cmd_i.fin2) begin
        if (fo_q[ch] > 43'sd8388607) begin
          out_q[ch] <= 24'sh7FFFFF;
        end else if (fo_q[ch] < -43'sd8388608) begin
          out_q[ch] <= -24'sh800000;
        end else begin
          out_q[ch] <= fo_q[ch][23:0];
        end
      end
    end
    if (cmd_i.fin1) begin
      busy_q <= act_cnt[4:0];
    end
    if (cmd_i.fin2) begin
      out_busy_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd;
      if (cmd_i.fin2) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.vel_nz     = (velocity_i != '0);
  assign sts_o.slot_hit   = slot_hit;
  assign sts_o.voice_live = voice_live;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  assign out_left_o    = out_q[0];
  assign out_right_o   = out_q[1];
  assign voices_busy_o = out_busy_q;
  assign out_valid_o   = out_valid_q;

endmodule

// ===== rtl/drum_sample_voice_mixer_top.sv =====
// Polyphonic drum-sample player with Catmull-Rom interpolation.
// Input channel (in_valid_i / in_stall_o) carries one item: func_i selects
// tick, note-on, sample word load or slot setting write. Only a tick gives a
// result on the output channel (out_valid_o / out_stall_i): the saturated
// stereo mix and the number of voices still playing.
// Loads and setting writes do not stall the input. A note-on checks each slot
// and spends an extra step on each slot that triggers. A tick checks each voice,
// and for each playing voice does four sample memory reads, one read wait,
// three cubic steps and two gain multiplies; it then scales and registers the
// result. The single read port of the sample memory and the shared cubic
// multiplier make these steps of a voice run one after another. One item is
// worked on at a time.
// A finished result sits in the output register; if the receiver stalls the
// block still takes load, setting and note-on items, and a following tick
// holds its result until the register is free.
// Reset clears slots and voices and sets master gain to unity. The sample
// memory is not cleared and must be loaded before it is played.
// master_gain lies at APB address 0; pready is always high.
module drum_sample_voice_mixer_top #(
  parameter int VOICES       = dsvm_pkg::VoicesDef,
  parameter int SLOTS        = dsvm_pkg::SlotsDef,
  parameter int SAMPLE_DEPTH = dsvm_pkg::SampleDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [6:0]         note_i,
  input  logic [6:0]         velocity_i,
  input  logic [3:0]         slot_index_i,
  input  logic [3:0]         setting_code_i,
  input  logic [23:0]        setting_value_i,
  input  logic [15:0]        sample_address_i,
  input  logic signed [15:0] sample_left_i,
  input  logic signed [15:0] sample_right_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] out_left_o,
  output logic signed [23:0] out_right_o,
  output logic [4:0]         voices_busy_o
);

  localparam int VoiceW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SlotW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [15:0] master_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_gain_q <= dsvm_pkg::MasterGainReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      master_gain_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, master_gain_q};

  dsvm_pkg::cmd_t    cmd;
  dsvm_pkg::sts_t    sts;
  logic [VoiceW-1:0] vidx;
  logic [SlotW-1:0]  sidx;
  logic [1:0]        phase;

  dsvm_ctrl #(
    .VOICES(VOICES),
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .func_i    (func_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .vidx_o    (vidx),
    .sidx_o    (sidx),
    .phase_o   (phase)
  );

  dsvm_dp #(
    .VOICES      (VOICES),
    .SLOTS       (SLOTS),
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .vidx_i          (vidx),
    .sidx_i          (sidx),
    .phase_i         (phase),
    .note_i          (note_i),
    .velocity_i      (velocity_i),
    .slot_index_i    (slot_index_i),
    .setting_code_i  (setting_code_i),
    .setting_value_i (setting_value_i),
    .sample_address_i(sample_address_i),
    .sample_left_i   (sample_left_i),
    .sample_right_i  (sample_right_i),
    .master_gain_i   (master_gain_q),
    .out_left_o      (out_left_o),
    .out_right_o     (out_right_o),
    .voices_busy_o   (voices_busy_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule
